[sv/nnu_pkg.sv]
// Shared types, constants and codes of the nearest-neighbour image upscaler.
package nnu_pkg;

  // Largest scaled dimension and largest enlargement order.
  localparam int DIM_MAX   = 256;
  localparam int ORDER_MAX = 4;

  // Fixed widths of the source image and the frame store.
  localparam int PIX_W   = 8;
  localparam int ADDR_W  = 16;
  localparam int STORE_DEPTH = 65536;
  localparam int SCALE_W = 3;
  localparam int DIM_W   = $clog2(DIM_MAX + 1);

  // Register interface.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_SCALE_ORDER = 1'b0;
  localparam logic [SCALE_W-1:0] SCALE_ORDER_RST = 3'd1;

  typedef enum logic [1:0] {
    REQ_HEADER = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_FETCH  = 2'd2
  } req_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic hdr;
    logic load;
    logic rd;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dims_zero;
  } sts_t;

endpackage

[sv/nnu_if.sv]
// Request and response channel interfaces of the upscaler.
interface nnu_req_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic [nnu_pkg::PIX_W-1:0] src_width;
  logic [nnu_pkg::PIX_W-1:0] src_height;
  logic [nnu_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, req_type, src_width, src_height, pixel_in, input ready);
  modport sink   (input valid, req_type, src_width, src_height, pixel_in, output ready);
endinterface

interface nnu_rsp_if #(
  parameter int DIM_W = nnu_pkg::DIM_W
);
  logic                     valid;
  logic                     ready;
  logic [nnu_pkg::PIX_W-1:0] pixel_out;
  logic [DIM_W-1:0]         scaled_width;
  logic [DIM_W-1:0]         scaled_height;
  logic                     last_pixel;

  modport source (output valid, pixel_out, scaled_width, scaled_height, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_out, scaled_width, scaled_height, last_pixel,
                  output ready);
endinterface

[sv/nnu_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module nnu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/nnu_ctrl.sv]
// Controller state machine of the upscaler: request decode and output handshake.
module nnu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    req_type_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  input  nnu_pkg::sts_t sts_i,
  output nnu_pkg::cmd_t cmd_o
);

  nnu_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nnu_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      nnu_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (nnu_pkg::req_e'(req_type_i))
            nnu_pkg::REQ_HEADER: cmd_o.hdr = 1'b1;
            nnu_pkg::REQ_LOAD:   cmd_o.load = 1'b1;
            nnu_pkg::REQ_FETCH: begin
              // With an empty scaled image a fetch is taken and dropped.
              if (!sts_i.dims_zero) begin
                cmd_o.rd = 1'b1;
                state_d  = nnu_pkg::S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      nnu_pkg::S_READ: begin
        // The store's read data holds until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = nnu_pkg::S_IDLE;
        end
      end
      default: state_d = nnu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_rd_enters_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |=> state_q == nnu_pkg::S_READ)
    else $error("fetch read did not enter the read state");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register loaded while holding an untaken result");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nnu_pkg::S_READ && out_valid_q && !out_ready_i) |=>
      (state_q == nnu_pkg::S_READ && out_valid_q))
    else $error("pending fetch left the read state during a stall");

  a_no_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.rd && sts_i.dims_zero))
    else $error("frame store read for an empty scaled image");

endmodule

[sv/nnu_dp.sv]
// Datapath of the upscaler: header arithmetic, scan counters, frame store, output register.
module nnu_dp #(
  parameter int MAX_DIM   = nnu_pkg::DIM_MAX,
  parameter int MAX_ORDER = nnu_pkg::ORDER_MAX,
  localparam int DW = $clog2(MAX_DIM + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  nnu_pkg::cmd_t               cmd_i,
  output nnu_pkg::sts_t               sts_o,
  input  logic [nnu_pkg::SCALE_W-1:0] scale_order_i,
  input  logic [nnu_pkg::PIX_W-1:0]   src_width_i,
  input  logic [nnu_pkg::PIX_W-1:0]   src_height_i,
  input  logic [nnu_pkg::PIX_W-1:0]   pixel_in_i,
  output logic [nnu_pkg::PIX_W-1:0]   pixel_out_o,
  output logic [DW-1:0]               scaled_width_o,
  output logic [DW-1:0]               scaled_height_o,
  output logic                        last_pixel_o
);

  localparam int PW   = nnu_pkg::PIX_W;
  localparam int AW   = nnu_pkg::ADDR_W;
  localparam int SW   = (PW + MAX_ORDER > DW) ? PW + MAX_ORDER : DW;
  localparam int OW   = $clog2(MAX_ORDER + 1);
  localparam int QN   = ((1 << PW) - 1) / MAX_DIM;
  localparam int QMAX = (QN > 1) ? QN : 1;
  localparam int QW   = $clog2(QMAX + 1);

  // Per-axis scan constants: scaled size, and the source step per scaled
  // pixel split into a whole part and a remainder over the scaled size.
  typedef struct packed {
    logic [DW-1:0] dest;
    logic [QW-1:0] q;
    logic [DW-1:0] r;
  } axis_t;

  function automatic logic fits(logic [PW-1:0] w, logic [PW-1:0] h, int k);
    logic [SW-1:0] sw;
    logic [SW-1:0] sh;
    sw = SW'(w) << k;
    sh = SW'(h) << k;
    return (sw <= SW'(MAX_DIM)) && (sh <= SW'(MAX_DIM));
  endfunction

  function automatic axis_t axis_calc(logic [PW-1:0] v, logic [OW-1:0] k);
    axis_t         a;
    logic [SW-1:0] sh;
    sh  = SW'(v) << k;
    a.q = '0;
    a.r = '0;
    if (sh > SW'(MAX_DIM)) begin
      // Clamped: the scaled size is the fixed maximum.
      a.dest = DW'(MAX_DIM);
      for (int n = 1; n <= QN; n++) begin
        if (SW'(v) >= SW'(n * MAX_DIM)) a.q = QW'(n);
      end
      a.r = DW'(SW'(v) - SW'(a.q) * SW'(MAX_DIM));
    end else begin
      a.dest = DW'(sh);
      if (k == '0) begin
        a.q = QW'(1);
      end else begin
        a.r = DW'(v);
      end
    end
    return a;
  endfunction

  logic [OW-1:0] ord_req, ord_sel;
  axis_t         ax_x, ax_y;
  logic [AW-1:0] bstep;

  always_comb begin
    if (int'(scale_order_i) > MAX_ORDER) begin
      ord_req = OW'(MAX_ORDER);
    end else begin
      ord_req = OW'(scale_order_i);
    end
    ord_sel = ord_req;
    if (!fits(src_width_i, src_height_i, int'(ord_req))) begin
      for (int j = 1; j < MAX_ORDER; j++) begin
        if (j < int'(ord_req) && fits(src_width_i, src_height_i, j)) ord_sel = OW'(j);
      end
    end
  end

  assign ax_x  = axis_calc(src_width_i, ord_sel);
  assign ax_y  = axis_calc(src_height_i, ord_sel);
  assign bstep = AW'(ax_y.q) * AW'(src_width_i);

  // Header-time constants and scan state.
  logic [PW-1:0] w_q;
  logic [DW-1:0] dw_q, dh_q;
  logic [QW-1:0] qx_q;
  logic [DW-1:0] rx_step_q, ry_step_q;
  logic [AW-1:0] bstep_q;
  logic [AW-1:0] ptr_q;
  logic [DW-1:0] col_q, row_q;
  logic [PW-1:0] sx_q;
  logic [DW-1:0] remx_q, remy_q;
  logic [AW-1:0] base_q;

  logic [DW:0]   remx_sum, remy_sum;
  logic          remx_ge, remy_ge;
  logic [DW-1:0] remx_nx, remy_nx;
  logic [PW-1:0] sx_nx;
  logic [AW-1:0] base_nx;
  logic          col_last, row_last;

  assign remx_sum = {1'b0, remx_q} + {1'b0, rx_step_q};
  assign remx_ge  = remx_sum >= {1'b0, dw_q};
  assign remx_nx  = remx_ge ? DW'(remx_sum - {1'b0, dw_q}) : DW'(remx_sum);
  assign sx_nx    = sx_q + PW'(qx_q) + PW'(remx_ge);

  assign remy_sum = {1'b0, remy_q} + {1'b0, ry_step_q};
  assign remy_ge  = remy_sum >= {1'b0, dh_q};
  assign remy_nx  = remy_ge ? DW'(remy_sum - {1'b0, dh_q}) : DW'(remy_sum);
  assign base_nx  = base_q + bstep_q + (remy_ge ? AW'(w_q) : '0);

  assign col_last = col_q == dw_q - DW'(1);
  assign row_last = row_q == dh_q - DW'(1);

  assign sts_o.dims_zero = (dw_q == '0) || (dh_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= '0;
      dw_q   <= '0;
      dh_q   <= '0;
      ptr_q  <= '0;
      col_q  <= '0;
      row_q  <= '0;
      sx_q   <= '0;
      remx_q <= '0;
      remy_q <= '0;
      base_q <= '0;
    end else if (cmd_i.hdr) begin
      w_q    <= src_width_i;
      dw_q   <= ax_x.dest;
      dh_q   <= ax_y.dest;
      ptr_q  <= '0;
      col_q  <= '0;
      row_q  <= '0;
      sx_q   <= '0;
      remx_q <= '0;
      remy_q <= '0;
      base_q <= '0;
    end else if (cmd_i.load) begin
      ptr_q <= ptr_q + AW'(1);
    end else if (cmd_i.out_load) begin
      if (col_last) begin
        col_q  <= '0;
        sx_q   <= '0;
        remx_q <= '0;
        if (row_last) begin
          row_q  <= '0;
          remy_q <= '0;
          base_q <= '0;
        end else begin
          row_q  <= row_q + DW'(1);
          remy_q <= remy_nx;
          base_q <= base_nx;
        end
      end else begin
        col_q  <= col_q + DW'(1);
        sx_q   <= sx_nx;
        remx_q <= remx_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr) begin
      qx_q      <= ax_x.q;
      rx_step_q <= ax_x.r;
      ry_step_q <= ax_y.r;
      bstep_q   <= bstep;
    end
  end

  logic [PW-1:0] rdata;
  logic [AW-1:0] raddr;

  assign raddr = base_q + AW'(sx_q);

  nnu_ram #(
    .WIDTH (PW),
    .DEPTH (nnu_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (ptr_q),
    .wdata_i (pixel_in_i),
    .re_i    (cmd_i.rd),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic [PW-1:0] pix_q;
  logic [DW-1:0] sw_q, sh_q;
  logic          last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pix_q  <= rdata;
      sw_q   <= dw_q;
      sh_q   <= dh_q;
      last_q <= col_last && row_last;
    end
  end

  assign pixel_out_o     = pix_q;
  assign scaled_width_o  = sw_q;
  assign scaled_height_o = sh_q;
  assign last_pixel_o    = last_q;

endmodule

[sv/nearest_neighbor_image_upscaler.sv]
// Top level of the nearest-neighbour image upscaler with its register port.
//
// Use: send a header transfer (req_type header) carrying the source width and
// height, then one load transfer per source pixel in raster order, then fetch
// transfers; each fetch that finds a non-empty scaled image returns one result
// transfer with the next scaled pixel in raster order, the scaled width and
// height, and a flag on the final pixel. After the final pixel the scan starts
// again at the top left corner. Header and load transfers give no result.
// The enlargement order is taken from the scale_order register when the
// header arrives; program it over the register port while the block is idle.
//
// Timing: header and load transfers are taken in the idle state, so they can be sent
// back to back. A fetch reads the frame store through its registered read port and
// then waits in the read state until the output register is free; the request is not
// ready while it waits. The result is valid once the read data is in the output register.
// While a result waits, header and load transfers are still taken and a
// following fetch waits in the read state until the output register is free.
//
// Reset clears the image dimensions, so fetches give nothing until a header
// arrives. The frame store is not cleared; pixels must be loaded before use.
module nearest_neighbor_image_upscaler #(
  parameter int MAX_DIM   = nnu_pkg::DIM_MAX,
  parameter int MAX_ORDER = nnu_pkg::ORDER_MAX
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  nnu_req_if.sink                    req_i,
  nnu_rsp_if.source                  rsp_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [nnu_pkg::APB_AW-1:0] paddr,
  input  logic [nnu_pkg::APB_DW-1:0] pwdata,
  output logic [nnu_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  localparam int DW = $clog2(MAX_DIM + 1);

  // Register port: a write lands on the access phase; reads are combinational.
  logic [nnu_pkg::SCALE_W-1:0] scale_order_q;
  logic                        reg_hit;

  assign reg_hit = paddr[nnu_pkg::APB_AW-1:2] == nnu_pkg::REG_SCALE_ORDER;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_order_q <= nnu_pkg::SCALE_ORDER_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      scale_order_q <= pwdata[nnu_pkg::SCALE_W-1:0];
    end
  end

  assign prdata = reg_hit ? nnu_pkg::APB_DW'(scale_order_q) : '0;

  // The controller decides what each transfer does; the datapath carries it out.
  nnu_pkg::cmd_t cmd;
  nnu_pkg::sts_t sts;

  nnu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .req_type_i  (req_i.req_type),
    .in_ready_o  (req_i.ready),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  logic [DW-1:0] scaled_width, scaled_height;

  nnu_dp #(
    .MAX_DIM   (MAX_DIM),
    .MAX_ORDER (MAX_ORDER)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .scale_order_i   (scale_order_q),
    .src_width_i     (req_i.src_width),
    .src_height_i    (req_i.src_height),
    .pixel_in_i      (req_i.pixel_in),
    .pixel_out_o     (rsp_o.pixel_out),
    .scaled_width_o  (scaled_width),
    .scaled_height_o (scaled_height),
    .last_pixel_o    (rsp_o.last_pixel)
  );

  assign rsp_o.scaled_width  = scaled_width;
  assign rsp_o.scaled_height = scaled_height;

endmodule

[test/testbench.sv]
// Self-checking testbench of the nearest-neighbour image upscaler: random frames, checked pixels.
`timescale 1ns / 1ps

module testbench;

  localparam int PW    = nnu_pkg::PIX_W;
  localparam int DW    = nnu_pkg::DIM_W;
  localparam int OW    = nnu_pkg::SCALE_W;
  localparam int DEPTH = nnu_pkg::STORE_DEPTH;

  // The fourth request code has no meaning; the block must ignore it.
  localparam logic [1:0] REQ_IGNORED = 2'd3;
  // The order register is the only register, so it sits at byte address zero.
  localparam logic [nnu_pkg::APB_AW-1:0] ADDR_SCALE_ORDER = {nnu_pkg::REG_SCALE_ORDER, 2'b00};

  // One scaled pixel as the response channel carries it.
  typedef struct packed {
    logic [PW-1:0] pix;
    logic [DW-1:0] width;
    logic [DW-1:0] height;
    logic          last;
  } scaled_pixel_t;

  // Tracks the frame store, the scan position and the latched image sizes, works out the
  // pixel that each accepted fetch must return, and checks the pixels that come back.
  class scaled_pixel_tracker;
    bit [PW-1:0]                  store_copy [DEPTH];
    bit                           loaded [DEPTH];
    bit [OW-1:0]                  order_reg;
    bit [nnu_pkg::ADDR_W-1:0]     load_ptr;
    int unsigned                  src_w, src_h, dst_w, dst_h, col, row;
    scaled_pixel_t                expected_pixels [$];
    int                           errors;

    function new();
      order_reg = nnu_pkg::SCALE_ORDER_RST;
      load_ptr  = '0;
      src_w = 0; src_h = 0; dst_w = 0; dst_h = 0; col = 0; row = 0;
      errors = 0;
    endfunction

    function void set_order(bit [OW-1:0] value);
      order_reg = value;
    endfunction

    function bit order_fits(int unsigned k);
      return ((src_w << k) <= nnu_pkg::DIM_MAX) && ((src_h << k) <= nnu_pkg::DIM_MAX);
    endfunction

    // The order is chosen here and held until the next header.
    function void take_header(int unsigned w, int unsigned h);
      int unsigned ord;
      bit          found;
      src_w = w;
      src_h = h;
      found = 1'b0;
      ord = (order_reg > nnu_pkg::ORDER_MAX) ? nnu_pkg::ORDER_MAX : order_reg;
      if (!order_fits(ord)) begin
        for (int unsigned k = ord; k > 1 && !found; k--) begin
          if (order_fits(k - 1)) begin
            ord   = k - 1;
            found = 1'b1;
          end
        end
      end
      dst_w = ((w << ord) > nnu_pkg::DIM_MAX) ? nnu_pkg::DIM_MAX : (w << ord);
      dst_h = ((h << ord) > nnu_pkg::DIM_MAX) ? nnu_pkg::DIM_MAX : (h << ord);
      load_ptr = '0;
      col = 0;
      row = 0;
    endfunction

    // Store address that the next fetch reads, or -1 when the fetch gives nothing.
    function int next_addr();
      int unsigned c, r, sx, sy;
      if (dst_w == 0 || dst_h == 0) return -1;
      c = col;
      r = row;
      if (c >= dst_w || r >= dst_h) begin
        c = 0;
        r = 0;
      end
      sx = c * src_w / dst_w;
      sy = r * src_h / dst_h;
      return int'((sy * src_w + sx) & 32'hFFFF);
    endfunction

    // A fetch may only be sent when it reads a loaded entry or gives no result.
    function bit fetch_safe();
      int a;
      a = next_addr();
      return (a < 0) || loaded[a];
    endfunction

    function void take_request(logic [1:0] req, logic [PW-1:0] w, logic [PW-1:0] h,
                               logic [PW-1:0] pix);
      int            a;
      scaled_pixel_t px;
      case (req)
        nnu_pkg::REQ_HEADER: take_header(w, h);
        nnu_pkg::REQ_LOAD: begin
          store_copy[load_ptr] = pix;
          loaded[load_ptr]     = 1'b1;
          load_ptr++;
        end
        nnu_pkg::REQ_FETCH: begin
          a = next_addr();
          if (a >= 0) begin
            if (col >= dst_w || row >= dst_h) begin
              col = 0;
              row = 0;
            end
            px.pix    = store_copy[a];
            px.width  = dst_w[DW-1:0];
            px.height = dst_h[DW-1:0];
            px.last   = (col == dst_w - 1) && (row == dst_h - 1);
            expected_pixels.push_back(px);
            col++;
            if (col >= dst_w) begin
              col = 0;
              row++;
              if (row >= dst_h) row = 0;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_pixel(scaled_pixel_t got);
      scaled_pixel_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel: pix=%0d w=%0d h=%0d last=%0b", $time,
                 got.pix, got.width, got.height, got.last);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got !== want) begin
        $display("%0t: pixel mismatch: expected pix=%0d w=%0d h=%0d last=%0b,",
                 $time, want.pix, want.width, want.height, want.last,
                 " actual pix=%0d w=%0d h=%0d last=%0b",
                 got.pix, got.width, got.height, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel, penable, pwrite, pready;
  logic [nnu_pkg::APB_AW-1:0]    paddr;
  logic [nnu_pkg::APB_DW-1:0]    pwdata, prdata;

  nnu_req_if req_ch ();
  nnu_rsp_if rsp_ch ();

  scaled_pixel_tracker tracker = new();

  // Sender pacing: a burst of back-to-back transfers, then, while gap_max is not zero, a gap of idle cycles.
  int burst_left = 0;
  int burst_max  = 24;
  int gap_max    = 6;
  int sent_items = 0;

  nearest_neighbor_image_upscaler dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit, several times the slowest correct run.
  initial begin
    #200_000;
    $display("nearest_neighbor_image_upscaler test failed");
    $finish;
  end

  // The receiver stalls on a pattern of its own, in modes chosen at random and changed now and then:
  // always ready, random stalls, short regular stalls, or long stalls.
  initial begin
    int mode, mode_left, run;
    bit level;
    mode = 0;
    mode_left = 0;
    run = 0;
    level = 1'b1;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(100, 400);
      end
      mode_left--;
      case (mode)
        0: rsp_ch.ready = 1'b1;
        1: rsp_ch.ready = ($urandom_range(0, 3) != 0);
        default: begin
          if (run == 0) begin
            level = ~level;
            if (mode == 2) run = level ? $urandom_range(1, 4) : $urandom_range(1, 2);
            else           run = level ? $urandom_range(1, 3) : $urandom_range(2, 8);
          end
          run--;
          rsp_ch.ready = level;
        end
      endcase
    end
  end

  // Every accepted result transfer is checked against the oldest expected pixel.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      tracker.check_pixel({rsp_ch.pixel_out, rsp_ch.scaled_width, rsp_ch.scaled_height,
                           rsp_ch.last_pixel});
    end
  end

  function automatic logic [PW-1:0] rand_byte();
    return PW'($urandom_range(0, 255));
  endfunction

  // Presents one request and holds it until the transfer happens. The tracker is told from
  // this process, so the next request is always chosen from up-to-date state.
  task automatic send_item(logic [1:0] req, logic [PW-1:0] w, logic [PW-1:0] h,
                           logic [PW-1:0] pix);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        gap = $urandom_range(1, gap_max);
        req_ch.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, burst_max);
    end
    burst_left--;
    req_ch.req_type   = req;
    req_ch.src_width  = w;
    req_ch.src_height = h;
    req_ch.pixel_in   = pix;
    req_ch.valid      = 1'b1;
    do @(posedge clk_i); while (!req_ch.ready);
    tracker.take_request(req, w, h, pix);
    sent_items++;
  endtask

  // Sends a fetch when it reads loaded pixels, otherwise a load that fills the store.
  task automatic send_fetch_or_load();
    if (tracker.fetch_safe()) begin
      send_item(nnu_pkg::REQ_FETCH, rand_byte(), rand_byte(), rand_byte());
    end else begin
      send_item(nnu_pkg::REQ_LOAD, rand_byte(), rand_byte(), rand_byte());
    end
  endtask

  // Occasional request with the unused code, random fields.
  task automatic maybe_noise();
    if ($urandom_range(0, 15) == 0) begin
      send_item(REQ_IGNORED, rand_byte(), rand_byte(), rand_byte());
    end
  endtask

  // Lets the request side go quiet, waits for every expected pixel, and then lets the block
  // settle further before returning.
  task automatic wait_idle();
    @(negedge clk_i);
    req_ch.valid = 1'b0;
    burst_left = 0;
    while (tracker.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes the order register (junk in the upper bits, which the block drops) and reads it
  // back. Only called while the block is idle.
  task automatic write_scale_order(bit [OW-1:0] value);
    logic [nnu_pkg::APB_DW-1:0] data;
    data = $urandom;
    data[OW-1:0] = value;
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = ADDR_SCALE_ORDER; pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_order(value);
    @(negedge clk_i);
    penable = 1'b0; pwrite = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[OW-1:0] !== value) begin
      $display("%0t: scale_order read back: expected %0d, actual %0d", $time, value,
               prdata[OW-1:0]);
      tracker.errors++;
    end
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0;
  endtask

  // One frame: header, loads, fetches. Most frames are well formed; some have an empty
  // dimension, some load only part of the image, and noise is mixed in.
  task automatic random_frame();
    int shape, w, h, n_load, area, n_fetch;
    shape = $urandom_range(0, 19);
    if (shape == 0) begin
      w = $urandom_range(0, 1) ? 0 : $urandom_range(0, 255);
      h = (w == 0) ? $urandom_range(0, 255) : 0;
    end else if (shape <= 2) begin
      w = $urandom_range(0, 1) ? 255 : $urandom_range(100, 255);
      h = $urandom_range(1, 2);
      if (shape == 2) begin
        h = w;
        w = $urandom_range(1, 2);
      end
    end else if ($urandom_range(0, 1)) begin
      w = $urandom_range(1, 2);
      h = $urandom_range(1, 2);
    end else begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 8);
    end
    send_item(nnu_pkg::REQ_HEADER, PW'(w), PW'(h), rand_byte());

    n_load = w * h;
    if ($urandom_range(0, 7) == 0 && n_load > 0) n_load = $urandom_range(0, n_load - 1);
    if ($urandom_range(0, 9) == 0) n_load += $urandom_range(1, 5);
    // Long thin images are mostly loaded on demand as the fetches reach them.
    if (shape == 1 || shape == 2) n_load = $urandom_range(0, 16);
    if (shape == 0) n_load = $urandom_range(0, 3);
    for (int i = 0; i < n_load; i++) begin
      maybe_noise();
      send_item(nnu_pkg::REQ_LOAD, rand_byte(), rand_byte(), rand_byte());
    end

    area = tracker.dst_w * tracker.dst_h;
    if (shape == 0)      n_fetch = 3;
    else if (area <= 48) n_fetch = area;
    else                 n_fetch = $urandom_range(16, 48);
    if ($urandom_range(0, 3) == 0 && area > 0) begin
      n_fetch += $urandom_range(1, (area < 16) ? area : 16);
    end
    for (int i = 0; i < n_fetch; i++) begin
      maybe_noise();
      send_fetch_or_load();
    end
  endtask

  initial begin
    bit [OW-1:0] phase_orders [8];
    int          phase_start;
    phase_orders = '{3'd0, 3'd4, 3'd7, 3'd2, 3'd1, 3'd5, 3'd3, 3'd6};

    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = nnu_pkg::REQ_HEADER;
    req_ch.src_width  = '0;
    req_ch.src_height = '0;
    req_ch.pixel_in   = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, with the order left at its reset value. A fetch before any header and
    // a fetch on an image with a zero width both give nothing; the unused code is ignored.
    send_item(nnu_pkg::REQ_FETCH, 8'hFF, 8'hFF, 8'hFF);
    send_item(REQ_IGNORED, 8'hFF, 8'hFF, 8'hFF);
    send_item(nnu_pkg::REQ_HEADER, 8'd0, 8'd5, 8'h00);
    send_item(nnu_pkg::REQ_FETCH, 8'h00, 8'h00, 8'h00);
    // A single pixel enlarged to two by two; the fifth fetch wraps back to the top left.
    send_item(nnu_pkg::REQ_HEADER, 8'd1, 8'd1, 8'h00);
    send_item(nnu_pkg::REQ_LOAD, 8'h00, 8'h00, 8'hFF);
    repeat (5) send_item(nnu_pkg::REQ_FETCH, 8'h00, 8'h00, 8'h00);
    // A two by one image with pixels 00 and 5A, and a header that restarts a half-read scan.
    send_item(nnu_pkg::REQ_HEADER, 8'd2, 8'd1, 8'hFF);
    send_item(nnu_pkg::REQ_LOAD, 8'hFF, 8'hFF, 8'h00);
    send_item(nnu_pkg::REQ_LOAD, 8'h00, 8'h00, 8'h5A);
    repeat (3) send_item(nnu_pkg::REQ_FETCH, 8'h00, 8'h00, 8'h00);
    send_item(nnu_pkg::REQ_HEADER, 8'd2, 8'd1, 8'h00);
    repeat (9) send_item(nnu_pkg::REQ_FETCH, 8'hFF, 8'hFF, 8'hFF);

    // The largest source image, clamped on both axes; pixels are loaded as the scan
    // reaches them.
    send_item(nnu_pkg::REQ_HEADER, 8'd255, 8'd255, 8'h00);
    for (int i = 0; i < 60; i++) send_fetch_or_load();

    // Random phases, one order setting each, the extremes among them. Right after each
    // write a few fetches continue the previous frame, whose order must not change.
    foreach (phase_orders[p]) begin
      wait_idle();
      write_scale_order(phase_orders[p]);
      for (int i = 0; i < 8; i++) begin
        if (tracker.fetch_safe()) begin
          send_item(nnu_pkg::REQ_FETCH, rand_byte(), rand_byte(), rand_byte());
        end
      end
      if (p % 3 == 2) gap_max = 0;
      else            gap_max = 6;
      phase_start = sent_items;
      while (sent_items - phase_start < 40) random_frame();
    end

    @(negedge clk_i);
    req_ch.valid = 1'b0;
    for (int i = 0; i < 2000 && tracker.expected_pixels.size() != 0; i++) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.expected_pixels.size() == 0) begin
      $display("nearest_neighbor_image_upscaler test passed");
    end else begin
      $display("nearest_neighbor_image_upscaler test failed");
    end
    $finish;
  end

endmodule
